// ===== rtl/core/fdsr_pkg.sv =====
`timescale 1ns / 1ps

package fdsr_pkg;

    // Micrometre and steps-per-second quantities
    typedef logic [15:0] t_u16;

    // Request kinds carried by req_type
    localparam logic REQ_SAMPLE = 1'b0;
    localparam logic REQ_TICK   = 1'b1;

    // Configuration register indexes
    typedef enum logic [2:0] {
        CFG_TARGET     = 3'd0,
        CFG_OUTLIER    = 3'd1,
        CFG_DEADBAND   = 3'd2,
        CFG_SPEED_STEP = 3'd3,
        CFG_INTERVAL   = 3'd4,
        CFG_INIT_SPEED = 3'd5
    } t_cfg_idx;

    // Reset values of the configuration registers
    localparam t_u16 TARGET_RST     = 16'd1750;
    localparam t_u16 OUTLIER_RST    = 16'd200;
    localparam t_u16 DEADBAND_RST   = 16'd20;
    localparam t_u16 SPEED_STEP_RST = 16'd5;
    localparam t_u16 INTERVAL_RST   = 16'd10000;
    localparam t_u16 INIT_SPEED_RST = 16'd320;

    // Starting diameter held in every window entry after reset
    localparam int unsigned START_DIAM_INT = 1750;
    localparam t_u16        START_DIAM     = 16'd1750;

    // Millisecond timer saturates here
    localparam logic [16:0] MS_MAX = 17'h1FFFF;
    localparam t_u16        U16_MAX = 16'hFFFF;

endpackage

// ===== rtl/core/fdsr_window.sv =====
`timescale 1ns / 1ps

module fdsr_window #(
    parameter int WINDOW = 10
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_take,
    input  fdsr_pkg::t_u16     i_diameter_um,
    output fdsr_pkg::t_u16     o_average_um
);

    localparam int SLOT_W = $clog2(WINDOW);
    localparam int SUM_W  = 16 + $clog2(WINDOW);
    // Reciprocal of WINDOW, exact floor for every sum below 2**SUM_W
    localparam int DIV_SH = SUM_W + $clog2(WINDOW);
    localparam int PROD_W = SUM_W + DIV_SH;
    localparam longint unsigned DIV_M = ((64'd1 << DIV_SH) + WINDOW - 1) / WINDOW;
    localparam logic [SUM_W-1:0] SUM_RST = SUM_W'(fdsr_pkg::START_DIAM_INT * WINDOW);

    fdsr_pkg::t_u16    r_store [WINDOW];
    logic [SLOT_W-1:0] r_slot;
    logic [SLOT_W-1:0] n_slot;
    logic [SUM_W-1:0]  r_sum;
    logic [SUM_W-1:0]  n_sum;
    fdsr_pkg::t_u16    r_average;
    logic [PROD_W-1:0] w_prod;

    // Swap the oldest entry out of the running sum
    assign n_sum  = r_sum - SUM_W'(r_store[r_slot]) + SUM_W'(i_diameter_um);
    assign n_slot = (r_slot == SLOT_W'(WINDOW - 1)) ? '0 : r_slot + 1'b1;

    // Divide by the window through a reciprocal multiply
    assign w_prod = PROD_W'(n_sum) * PROD_W'(DIV_M);

    // Hold the ring, the sum and the average
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < WINDOW; k++) begin
                r_store[k] <= fdsr_pkg::START_DIAM;
            end
            r_slot    <= '0;
            r_sum     <= SUM_RST;
            r_average <= fdsr_pkg::START_DIAM;
        end else if (i_take) begin
            r_store[r_slot] <= i_diameter_um;
            r_slot          <= n_slot;
            r_sum           <= n_sum;
            r_average       <= w_prod[DIV_SH +: 16];
        end
    end

    assign o_average_um = r_average;

endmodule

// ===== rtl/core/filament_diameter_speed_regulator.sv =====
`timescale 1ns / 1ps
// A request is held in the input stage, then processed into the result register.
// Throughput: one request per cycle while the output is not stalled; the state
// update for a request is written as it is processed, so the next request sees it.
// Reset (synchronous, active low) loads the configuration defaults, fills the
// window with 1750 um, sets the speed to 320 steps/s and clears the timer.
module filament_diameter_speed_regulator #(
    parameter int WINDOW = 10
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    // request channel
    input  logic           i_in_valid,
    output logic           o_in_stall,
    input  logic           i_req_type,
    input  fdsr_pkg::t_u16 i_diameter_um,
    // result channel
    output logic           o_out_valid,
    input  logic           i_out_stall,
    output fdsr_pkg::t_u16 o_speed_sps,
    output fdsr_pkg::t_u16 o_average_um,
    output logic           o_sample_accepted,
    output logic           o_speed_changed,
    // configuration channel
    input  logic           i_cfg_valid,
    output logic           o_cfg_ready,
    input  logic [2:0]     i_cfg_index,
    input  fdsr_pkg::t_u16 i_cfg_data
);

    // Configuration registers
    fdsr_pkg::t_u16 r_target;
    fdsr_pkg::t_u16 r_outlier;
    fdsr_pkg::t_u16 r_deadband;
    fdsr_pkg::t_u16 r_speed_step;
    fdsr_pkg::t_u16 r_interval;
    fdsr_pkg::t_u16 r_init_speed;

    // Input stage
    logic           r_in_valid;
    logic           r_in_type;
    fdsr_pkg::t_u16 r_in_diam;

    // Controller state and result flags
    fdsr_pkg::t_u16 r_speed;
    logic [16:0]    r_ms;
    logic           r_out_valid;
    logic           r_out_acc;
    logic           r_out_chg;

    logic           w_fire;
    logic           w_take;
    fdsr_pkg::t_u16 w_average;
    fdsr_pkg::t_u16 w_dist;
    logic [16:0]    w_ms_inc;
    logic           w_due;
    logic           w_low;
    logic           w_high;
    logic [16:0]    w_up_sum;
    fdsr_pkg::t_u16 w_speed_dn;
    fdsr_pkg::t_u16 w_speed_up;
    fdsr_pkg::t_u16 n_speed;
    logic [16:0]    n_ms;
    logic           n_chg;

    // Process the held request whenever the result register can take it
    assign w_fire     = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !w_fire;
    assign o_cfg_ready = 1'b1;

    // Outlier check against the current average
    assign w_dist = (r_in_diam >= w_average) ? (r_in_diam - w_average)
                                             : (w_average - r_in_diam);
    assign w_take = w_fire && (r_in_type == fdsr_pkg::REQ_SAMPLE) && (w_dist < r_outlier);

    fdsr_window #(
        .WINDOW (WINDOW)
    ) u_window (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_take        (w_take),
        .i_diameter_um (r_in_diam),
        .o_average_um  (w_average)
    );

    // Advance the timer and decide on a correction
    assign w_ms_inc   = (r_ms == fdsr_pkg::MS_MAX) ? r_ms : r_ms + 17'd1;
    assign w_due      = w_ms_inc > {1'b0, r_interval};
    assign w_low      = ({1'b0, w_average} + {1'b0, r_deadband}) < {1'b0, r_target};
    assign w_high     = {1'b0, w_average} > ({1'b0, r_target} + {1'b0, r_deadband});
    assign w_up_sum   = {1'b0, r_speed} + {1'b0, r_speed_step};
    assign w_speed_dn = (r_speed > r_speed_step) ? (r_speed - r_speed_step) : '0;
    assign w_speed_up = w_up_sum[16] ? fdsr_pkg::U16_MAX : w_up_sum[15:0];

    always_comb begin
        n_speed = r_speed;
        n_ms    = w_ms_inc;
        n_chg   = 1'b0;
        if (w_due) begin
            n_ms = '0;
            if (w_low) begin
                n_speed = w_speed_dn;
                n_chg   = 1'b1;
            end else if (w_high) begin
                n_speed = w_speed_up;
                n_chg   = 1'b1;
            end
        end
    end

    // Write configuration registers; unknown indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target     <= fdsr_pkg::TARGET_RST;
            r_outlier    <= fdsr_pkg::OUTLIER_RST;
            r_deadband   <= fdsr_pkg::DEADBAND_RST;
            r_speed_step <= fdsr_pkg::SPEED_STEP_RST;
            r_interval   <= fdsr_pkg::INTERVAL_RST;
            r_init_speed <= fdsr_pkg::INIT_SPEED_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (fdsr_pkg::t_cfg_idx'(i_cfg_index))
                fdsr_pkg::CFG_TARGET:     r_target     <= i_cfg_data;
                fdsr_pkg::CFG_OUTLIER:    r_outlier    <= i_cfg_data;
                fdsr_pkg::CFG_DEADBAND:   r_deadband   <= i_cfg_data;
                fdsr_pkg::CFG_SPEED_STEP: r_speed_step <= i_cfg_data;
                fdsr_pkg::CFG_INTERVAL:   r_interval   <= i_cfg_data;
                fdsr_pkg::CFG_INIT_SPEED: r_init_speed <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Capture a request into the input stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in_valid && !o_in_stall) begin
            r_in_valid <= 1'b1;
        end else if (w_fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_in_type <= i_req_type;
            r_in_diam <= i_diameter_um;
        end
    end

    // Update speed and timer on a tick; reset loads the default start speed
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_speed <= fdsr_pkg::INIT_SPEED_RST;
            r_ms    <= '0;
        end else if (w_fire && (r_in_type == fdsr_pkg::REQ_TICK)) begin
            r_speed <= n_speed;
            r_ms    <= n_ms;
        end
    end

    // Load the result register; hold it while the output is stalled
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_fire) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_out_acc <= w_take;
            r_out_chg <= (r_in_type == fdsr_pkg::REQ_TICK) && n_chg;
        end
    end

    // State changes only when a request is processed, so it is the result
    assign o_out_valid       = r_out_valid;
    assign o_speed_sps       = r_speed;
    assign o_average_um      = w_average;
    assign o_sample_accepted = r_out_acc;
    assign o_speed_changed   = r_out_chg;

    // Speed moves only on a processed tick
    a_speed_only_on_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_fire && (r_in_type == fdsr_pkg::REQ_TICK)) |=> $stable(r_speed))
        else $error("speed changed without a processed tick");

    // Timer holds across samples
    a_ms_holds_on_sample: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire && (r_in_type == fdsr_pkg::REQ_SAMPLE)) |=> $stable(r_ms))
        else $error("timer moved on a sample");

    // Average holds while a result waits
    a_average_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_out_stall) |=> $stable(w_average))
        else $error("average changed under a stalled result");

    // Every processed request produces a result
    a_fire_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fire |=> r_out_valid)
        else $error("processed request lost its result");

endmodule

// ===== tb/sv/filament_diameter_speed_regulator_tb.sv =====
`timescale 1ns / 1ps

module filament_diameter_speed_regulator_tb;

    localparam int WIN          = 10;
    localparam int STALL_MAX    = 14;
    localparam int PHASE_ITEMS  = 85;
    localparam int RAND_PHASES  = 8;
    localparam int FEED_DEPTH   = 4;
    localparam int HOLD_PHASE   = 3;
    localparam int HOLD_CYCLES  = 60;
    localparam logic [2:0] CFG_SPARE_LO = 3'd6;
    localparam logic [2:0] CFG_SPARE_HI = 3'd7;

    typedef struct packed {
        logic           req_type;
        fdsr_pkg::t_u16 diameter_um;
    } t_diam_req;

    typedef struct packed {
        fdsr_pkg::t_u16 speed_sps;
        fdsr_pkg::t_u16 average_um;
        logic           sample_accepted;
        logic           speed_changed;
    } t_regulator_out;

    logic           i_clk             = 1'b0;
    logic           i_rst_n           = 1'b0;
    logic           i_in_valid        = 1'b0;
    logic           o_in_stall;
    logic           i_req_type        = fdsr_pkg::REQ_SAMPLE;
    fdsr_pkg::t_u16 i_diameter_um     = '0;
    logic           o_out_valid;
    logic           i_out_stall       = 1'b0;
    fdsr_pkg::t_u16 o_speed_sps;
    fdsr_pkg::t_u16 o_average_um;
    logic           o_sample_accepted;
    logic           o_speed_changed;
    logic           i_cfg_valid       = 1'b0;
    logic           o_cfg_ready;
    logic [2:0]     i_cfg_index       = fdsr_pkg::CFG_TARGET;
    fdsr_pkg::t_u16 i_cfg_data        = '0;

    // Regulator settings and state as the predictor sees them
    fdsr_pkg::t_u16 set_target;
    fdsr_pkg::t_u16 set_band;
    fdsr_pkg::t_u16 set_deadband;
    fdsr_pkg::t_u16 set_step;
    fdsr_pkg::t_u16 set_interval;
    fdsr_pkg::t_u16 set_init_speed;
    fdsr_pkg::t_u16 ring_um [WIN];
    int unsigned    ring_slot;
    int unsigned    ring_sum;
    fdsr_pkg::t_u16 avg_um;
    fdsr_pkg::t_u16 speed_now;
    logic [16:0]    ms_count;

    t_diam_req      req_backlog[$];
    t_regulator_out expected_readings[$];

    t_diam_req      tx_req;
    t_regulator_out predicted;
    t_regulator_out want;
    bit             sent_now;
    bit             tx_calm     = 1'b0;
    bit             rx_calm     = 1'b0;
    int             tx_wait     = 0;
    int             rx_wait     = 0;
    bit             hold_go     = 1'b0;
    logic           rx_hold     = 1'b0;
    int             mismatches  = 0;

    filament_diameter_speed_regulator #(
        .WINDOW(WIN)
    ) u_top (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_stall        (o_in_stall),
        .i_req_type        (i_req_type),
        .i_diameter_um     (i_diameter_um),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_speed_sps       (o_speed_sps),
        .o_average_um      (o_average_um),
        .o_sample_accepted (o_sample_accepted),
        .o_speed_changed   (o_speed_changed),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Load the reset state into the predictor
    task automatic reset_regulator_model();
        int k;
        set_target     = fdsr_pkg::TARGET_RST;
        set_band       = fdsr_pkg::OUTLIER_RST;
        set_deadband   = fdsr_pkg::DEADBAND_RST;
        set_step       = fdsr_pkg::SPEED_STEP_RST;
        set_interval   = fdsr_pkg::INTERVAL_RST;
        set_init_speed = fdsr_pkg::INIT_SPEED_RST;
        for (k = 0; k < WIN; k++)
            ring_um[k] = fdsr_pkg::START_DIAM;
        ring_slot = 0;
        ring_sum  = fdsr_pkg::START_DIAM_INT * WIN;
        avg_um    = fdsr_pkg::START_DIAM;
        speed_now = set_init_speed;
        ms_count  = '0;
    endtask

    // Apply one request to the predicted regulator and return its reading
    task automatic advance_regulator(input t_diam_req rq, output t_regulator_out res);
        int unsigned d;
        int unsigned a;
        int unsigned gap;
        int unsigned raised;
        d = rq.diameter_um;
        a = avg_um;
        res.sample_accepted = 1'b0;
        res.speed_changed   = 1'b0;
        if (rq.req_type == fdsr_pkg::REQ_SAMPLE) begin
            gap = (d >= a) ? d - a : a - d;
            // keep only samples strictly inside the outlier band
            if (gap < set_band) begin
                ring_sum = ring_sum - ring_um[ring_slot] + d;
                ring_um[ring_slot] = rq.diameter_um;
                ring_slot = (ring_slot == WIN - 1) ? 0 : ring_slot + 1;
                avg_um = fdsr_pkg::t_u16'(ring_sum / WIN);
                res.sample_accepted = 1'b1;
            end
        end else begin
            if (ms_count != fdsr_pkg::MS_MAX)
                ms_count = ms_count + 17'd1;
            // correct outside the deadband once the interval has passed
            if (ms_count > {1'b0, set_interval}) begin
                if (a + set_deadband < set_target) begin
                    speed_now = (speed_now > set_step) ? speed_now - set_step : '0;
                    res.speed_changed = 1'b1;
                end else if (a > set_target + 32'(set_deadband)) begin
                    raised = speed_now + 32'(set_step);
                    speed_now = (raised > fdsr_pkg::U16_MAX) ? fdsr_pkg::U16_MAX
                                                             : fdsr_pkg::t_u16'(raised);
                    res.speed_changed = 1'b1;
                end
                ms_count = '0;
            end
        end
        res.speed_sps  = speed_now;
        res.average_um = avg_um;
    endtask

    task automatic check_field(input string name, input logic [15:0] exp_v,
                               input logic [15:0] got_v);
        if (got_v !== exp_v) begin
            $display("%0t ns: %s expected %0d, got %0d", $time, name, exp_v, got_v);
            mismatches++;
        end
    endtask

    // Request driver: hold the payload until taken, then pause a drawn number of cycles
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            tx_wait = 0;
        end else begin
            sent_now = i_in_valid && !o_in_stall;
            if (sent_now) begin
                advance_regulator(tx_req, predicted);
                expected_readings.push_back(predicted);
            end
            if (!i_in_valid || sent_now) begin
                if (rx_hold)
                    tx_wait = 0;
                if (tx_wait > 0) begin
                    tx_wait--;
                    i_in_valid <= 1'b0;
                end else if (req_backlog.size() > 0) begin
                    tx_req = req_backlog.pop_front();
                    i_in_valid    <= 1'b1;
                    i_req_type    <= tx_req.req_type;
                    i_diameter_um <= tx_req.diameter_um;
                    if ($urandom_range(0, 29) == 0)
                        tx_calm = !tx_calm;
                    tx_wait = tx_calm ? 0 : $urandom_range(0, STALL_MAX);
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor: compare each reading, then stall a drawn number of cycles
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
            rx_wait = 0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (expected_readings.size() == 0) begin
                    $display("%0t ns: reading with nothing expected, speed %0d average %0d",
                             $time, o_speed_sps, o_average_um);
                    mismatches++;
                end else begin
                    want = expected_readings.pop_front();
                    check_field("speed_sps", want.speed_sps, o_speed_sps);
                    check_field("average_um", want.average_um, o_average_um);
                    check_field("sample_accepted", 16'(want.sample_accepted),
                                16'(o_sample_accepted));
                    check_field("speed_changed", 16'(want.speed_changed),
                                16'(o_speed_changed));
                end
                if ($urandom_range(0, 29) == 0)
                    rx_calm = !rx_calm;
                rx_wait = rx_calm ? 0 : $urandom_range(0, STALL_MAX);
            end
            if (rx_hold) begin
                i_out_stall <= 1'b1;
            end else if (rx_wait > 0) begin
                rx_wait--;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    // Back-pressure burst: hold the result side while requests keep coming
    initial begin
        do @(posedge i_clk);
        while (!hold_go);
        rx_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        rx_hold <= 1'b0;
    end

    task automatic queue_req(input logic kind, input fdsr_pkg::t_u16 d);
        t_diam_req rq;
        rq.req_type    = kind;
        rq.diameter_um = d;
        req_backlog.push_back(rq);
    endtask

    // Wait until every request is taken and every reading has come back
    task automatic drain();
        do @(negedge i_clk);
        while (req_backlog.size() != 0 || i_in_valid || expected_readings.size() != 0);
        repeat (3) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input fdsr_pkg::t_u16 val);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(negedge i_clk);
        while (!o_cfg_ready) @(negedge i_clk);
        @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        case (idx)
            fdsr_pkg::CFG_TARGET:     set_target     = val;
            fdsr_pkg::CFG_OUTLIER:    set_band       = val;
            fdsr_pkg::CFG_DEADBAND:   set_deadband   = val;
            fdsr_pkg::CFG_SPEED_STEP: set_step       = val;
            fdsr_pkg::CFG_INTERVAL:   set_interval   = val;
            fdsr_pkg::CFG_INIT_SPEED: set_init_speed = val;
            default: ;
        endcase
    endtask

    // Mostly a typical value, sometimes one of the extremes
    function automatic fdsr_pkg::t_u16 pick_value(input int unsigned ext_lo,
                                                  input int unsigned typ_lo,
                                                  input int unsigned typ_hi);
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r < 2)
            return fdsr_pkg::t_u16'(ext_lo);
        if (r < 4)
            return fdsr_pkg::U16_MAX;
        return fdsr_pkg::t_u16'($urandom_range(typ_lo, typ_hi));
    endfunction

    task automatic pick_settings(input int p);
        write_reg(fdsr_pkg::CFG_TARGET, pick_value(0, 1000, 3000));
        write_reg(fdsr_pkg::CFG_OUTLIER, (p == 1) ? fdsr_pkg::U16_MAX : pick_value(0, 1, 500));
        write_reg(fdsr_pkg::CFG_DEADBAND, pick_value(0, 0, 60));
        write_reg(fdsr_pkg::CFG_SPEED_STEP, pick_value(0, 0, 300));
        write_reg(fdsr_pkg::CFG_INTERVAL, (p == 2) ? fdsr_pkg::U16_MAX : pick_value(1, 1, 12));
        write_reg(fdsr_pkg::CFG_INIT_SPEED, fdsr_pkg::t_u16'($urandom_range(0, 65535)));
    endtask

    // Ticks, samples around the average drifting toward the target, and noise
    function automatic t_diam_req make_random_req();
        t_diam_req   rq;
        int unsigned pick;
        int unsigned off;
        int          v;
        pick = $urandom_range(0, 99);
        rq.req_type    = fdsr_pkg::REQ_SAMPLE;
        rq.diameter_um = fdsr_pkg::t_u16'($urandom_range(0, 65535));
        if (pick < 35) begin
            rq.req_type = fdsr_pkg::REQ_TICK;
        end else if (pick < 88) begin
            off = $urandom_range(0, set_band);
            if ((set_target >= avg_um) == ($urandom_range(0, 9) < 6))
                v = int'(avg_um) + int'(off);
            else
                v = int'(avg_um) - int'(off);
            if (v < 0)
                v = 0;
            if (v > 65535)
                v = 65535;
            rq.diameter_um = fdsr_pkg::t_u16'(v);
        end
        return rq;
    endfunction

    task automatic feed_random_phase(input int p);
        int made;
        made = 0;
        while (made < PHASE_ITEMS) begin
            @(negedge i_clk);
            if (req_backlog.size() < FEED_DEPTH) begin
                req_backlog.push_back(make_random_req());
                made++;
                if (p == HOLD_PHASE && made == 20)
                    hold_go = 1'b1;
            end
        end
    endtask

    initial begin
        int p;
        reset_regulator_model();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Reset settings: band edges on both sides, equal to average, field extremes
        queue_req(fdsr_pkg::REQ_SAMPLE, 16'd1750);
        queue_req(fdsr_pkg::REQ_SAMPLE, 16'd1950);
        queue_req(fdsr_pkg::REQ_SAMPLE, 16'd1550);
        queue_req(fdsr_pkg::REQ_SAMPLE, 16'd1949);
        queue_req(fdsr_pkg::REQ_SAMPLE, 16'd1570);
        queue_req(fdsr_pkg::REQ_SAMPLE, 16'd0);
        queue_req(fdsr_pkg::REQ_SAMPLE, 16'hFFFF);
        queue_req(fdsr_pkg::REQ_SAMPLE, 16'd1752);
        queue_req(fdsr_pkg::REQ_TICK, 16'hFFFF);
        queue_req(fdsr_pkg::REQ_TICK, 16'd0);
        drain();

        // Zero band, interval of one, largest step down: speed pins at zero
        write_reg(fdsr_pkg::CFG_OUTLIER, 16'd0);
        write_reg(fdsr_pkg::CFG_INTERVAL, 16'd1);
        write_reg(fdsr_pkg::CFG_DEADBAND, 16'd0);
        write_reg(fdsr_pkg::CFG_SPEED_STEP, fdsr_pkg::U16_MAX);
        write_reg(fdsr_pkg::CFG_TARGET, fdsr_pkg::U16_MAX);
        write_reg(fdsr_pkg::CFG_INIT_SPEED, 16'd0);
        write_reg(CFG_SPARE_LO, 16'd7);
        write_reg(CFG_SPARE_HI, fdsr_pkg::U16_MAX);
        queue_req(fdsr_pkg::REQ_SAMPLE, 16'd1752);
        repeat (4) queue_req(fdsr_pkg::REQ_TICK, 16'd0);
        drain();

        // Target at zero: speed steps up and pins at the top
        write_reg(fdsr_pkg::CFG_TARGET, 16'd0);
        repeat (4) queue_req(fdsr_pkg::REQ_TICK, 16'd0);
        drain();

        // Average on the target, then the widest deadband: interval restarts only
        write_reg(fdsr_pkg::CFG_TARGET, 16'd1752);
        repeat (2) queue_req(fdsr_pkg::REQ_TICK, 16'd0);
        drain();
        write_reg(fdsr_pkg::CFG_TARGET, fdsr_pkg::U16_MAX);
        write_reg(fdsr_pkg::CFG_DEADBAND, fdsr_pkg::U16_MAX);
        repeat (2) queue_req(fdsr_pkg::REQ_TICK, 16'd0);
        drain();

        for (p = 0; p < RAND_PHASES; p++) begin
            pick_settings(p);
            feed_random_phase(p);
            drain();
        end

        repeat (10) @(posedge i_clk);
        if (mismatches == 0 && expected_readings.size() == 0)
            $display("filament_diameter_speed_regulator_tb passed");
        else
            $display("filament_diameter_speed_regulator_tb failed");
        $finish;
    end

    initial begin
        #5_000_000;
        $display("filament_diameter_speed_regulator_tb failed");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/core/fdsr_pkg.sv
rtl/core/fdsr_window.sv
rtl/core/filament_diameter_speed_regulator.sv
tb/sv/filament_diameter_speed_regulator_tb.sv
